/* rtl/core/ttps_pkg.sv */
// ----------------------------------------------------------------------------
// ttps_pkg
// Shared widths, field positions, codes and types of the probe/store unit.
// ----------------------------------------------------------------------------
package ttps_pkg;

  localparam int DEFAULT_INDEX_BITS = 12;

  localparam int KEY_W      = 64;
  localparam int WORD_W     = 64;
  localparam int MOVE_W     = 32;
  localparam int SCORE_W    = 21;
  localparam int SCOREPK_W  = 22;
  localparam int DEPTH_W    = 8;
  localparam int PLY_W      = 8;
  localparam int KIND_W     = 2;
  localparam int THR_W      = 20;
  localparam int ADJ_W      = 23;
  localparam int CFG_IDX_W  = 1;

  localparam int SCORE_POS  = 32;
  localparam int DEPTH_POS  = 54;
  localparam int KIND_POS   = 62;

  localparam logic [SCOREPK_W-1:0] SCORE_BIAS_PK = SCOREPK_W'(1 << 20);
  localparam logic signed [ADJ_W-1:0] SCORE_BIAS = ADJ_W'(1 << 20);

  localparam logic OP_PROBE = 1'b0;
  localparam logic OP_STORE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALPHA = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BETA  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 1'd1;

  localparam logic             ENABLE_RESET    = 1'b1;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 20'd48000;

  typedef struct packed {
    logic             enable;
    logic [THR_W-1:0] threshold;
  } ttps_cfg_t;

endpackage

/* rtl/core/ttps_mem.sv */
// ----------------------------------------------------------------------------
// ttps_mem
// Slot memory: check word and data word side by side, one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module ttps_mem
  import ttps_pkg::*;
#(
  parameter int INDEX_BITS = DEFAULT_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [INDEX_BITS-1:0] wr_addr,
  input  logic [2*WORD_W-1:0]   wr_data,
  input  logic                  rd_en,
  input  logic [INDEX_BITS-1:0] rd_addr,
  output logic [2*WORD_W-1:0]   rd_data_r
);

  logic [2*WORD_W-1:0] mem [2**INDEX_BITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/ttps_cfg.sv */
// ----------------------------------------------------------------------------
// ttps_cfg
// Configuration registers: table enable and mate score threshold.
// ----------------------------------------------------------------------------
module ttps_cfg
  import ttps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data,
  output ttps_cfg_t            cfg_r
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable    <= ENABLE_RESET;
      cfg_r.threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_ENABLE:    cfg_r.enable    <= cfg_data[0];
        CFG_IDX_THRESHOLD: cfg_r.threshold <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/transposition_table_probe_store_unit.sv */
// ----------------------------------------------------------------------------
// transposition_table_probe_store_unit
// Flow: an accepted item takes the slot memory read, two mate adjust steps
// (ADJ1, ADJ2) and writeback with the registered result strobe (FINISH);
// busy stays high throughout, so a new item is taken only once the result is out.
// Reset: busy for 2**INDEX_BITS cycles while a clear pass zeroes every slot.
// ----------------------------------------------------------------------------
module transposition_table_probe_store_unit
  import ttps_pkg::*;
#(
  parameter int INDEX_BITS = DEFAULT_INDEX_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_operation,
  input  logic [KEY_W-1:0]          in_key,
  input  logic signed [SCORE_W-1:0] in_alpha,
  input  logic signed [SCORE_W-1:0] in_beta,
  input  logic [DEPTH_W-1:0]        in_depth,
  input  logic [PLY_W-1:0]          in_ply,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic [KIND_W-1:0]         in_bound_kind,
  input  logic [MOVE_W-1:0]         in_best_move,
  output logic                      out_valid,
  output logic                      out_hit,
  output logic [MOVE_W-1:0]         out_found_move,
  output logic signed [SCORE_W-1:0] out_found_score,
  output logic [DEPTH_W-1:0]        out_found_depth,
  output logic [KIND_W-1:0]         out_found_kind,
  output logic                      out_cutoff_valid,
  output logic signed [SCORE_W-1:0] out_cutoff_score,
  output logic                      out_written,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [THR_W-1:0]          cfg_data
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADJ1,
    ST_ADJ2,
    ST_FINISH
  } state_t;

  state_t state_r;
  logic [INDEX_BITS-1:0] clr_cnt_r;

  ttps_cfg_t cfg_r;

  // captured item
  logic                      op_r;
  logic [KEY_W-1:0]          key_r;
  logic signed [SCORE_W-1:0] alpha_r;
  logic signed [SCORE_W-1:0] beta_r;
  logic [DEPTH_W-1:0]        depth_r;
  logic [PLY_W-1:0]          ply_r;
  logic signed [SCORE_W-1:0] score_r;
  logic [KIND_W-1:0]         kind_r;
  logic [MOVE_W-1:0]         move_r;

  logic                      match_r;
  logic signed [ADJ_W-1:0]   s_r;

  // memory port
  logic                  accept;
  logic                  wr_en;
  logic [INDEX_BITS-1:0] wr_addr;
  logic [2*WORD_W-1:0]   wr_data;
  logic [2*WORD_W-1:0]   rd_data_r;

  // datapath
  logic [WORD_W-1:0]         chk;
  logic [WORD_W-1:0]         dat;
  logic [DEPTH_W-1:0]        sdepth;
  logic [KIND_W-1:0]         skind;
  logic signed [ADJ_W-1:0]   unpacked;
  logic signed [ADJ_W-1:0]   thr_s;
  logic signed [ADJ_W-1:0]   neg_thr;
  logic signed [ADJ_W-1:0]   ply_s;
  logic signed [ADJ_W-1:0]   base1;
  logic signed [ADJ_W-1:0]   s1_nxt;
  logic signed [ADJ_W-1:0]   s2_nxt;
  logic signed [ADJ_W-1:0]   alpha_ext;
  logic signed [ADJ_W-1:0]   beta_ext;
  logic                      store_skip;
  logic                      store_go;
  logic [SCOREPK_W-1:0]      score_pk;
  logic [WORD_W-1:0]         new_dat;
  logic                      cut_nxt;
  logic signed [SCORE_W-1:0] cut_score_nxt;

  ttps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_r     (cfg_r)
  );

  ttps_mem #(
    .INDEX_BITS (INDEX_BITS)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (accept),
    .rd_addr   (in_key[INDEX_BITS-1:0]),
    .rd_data_r (rd_data_r)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign chk = rd_data_r[2*WORD_W-1:WORD_W];
  assign dat = rd_data_r[WORD_W-1:0];

  always_comb begin
    sdepth    = dat[DEPTH_POS +: DEPTH_W];
    skind     = dat[KIND_POS +: KIND_W];
    unpacked  = $signed({1'b0, dat[SCORE_POS +: SCOREPK_W]}) - SCORE_BIAS;
    thr_s     = $signed({{(ADJ_W-THR_W){1'b0}}, cfg_r.threshold});
    neg_thr   = -thr_s;
    ply_s     = $signed({{(ADJ_W-PLY_W){1'b0}}, ply_r});
    alpha_ext = $signed({{(ADJ_W-SCORE_W){alpha_r[SCORE_W-1]}}, alpha_r});
    beta_ext  = $signed({{(ADJ_W-SCORE_W){beta_r[SCORE_W-1]}}, beta_r});

    // first mate step: low side
    if (op_r == OP_PROBE) begin
      base1 = unpacked;
    end else begin
      base1 = $signed({{(ADJ_W-SCORE_W){score_r[SCORE_W-1]}}, score_r});
    end
    s1_nxt = base1;
    if (base1 < neg_thr) begin
      s1_nxt = (op_r == OP_PROBE) ? base1 + ply_s : base1 - ply_s;
    end

    // second mate step: high side
    s2_nxt = s_r;
    if (s_r > thr_s) begin
      s2_nxt = (op_r == OP_PROBE) ? s_r - ply_s : s_r + ply_s;
    end

    cut_nxt       = 1'b0;
    cut_score_nxt = '0;
    if (sdepth >= depth_r) begin
      priority if (skind == KIND_EXACT) begin
        cut_nxt       = 1'b1;
        cut_score_nxt = s_r[SCORE_W-1:0];
      end else if (skind == KIND_ALPHA && s_r <= alpha_ext) begin
        cut_nxt       = 1'b1;
        cut_score_nxt = alpha_r;
      end else if (skind == KIND_BETA && s_r >= beta_ext) begin
        cut_nxt       = 1'b1;
        cut_score_nxt = beta_r;
      end else begin
        cut_nxt = 1'b0;
      end
    end

    store_skip = match_r && (sdepth > depth_r) && (kind_r != KIND_EXACT);
    store_go   = (state_r == ST_FINISH) && (op_r == OP_STORE) && cfg_r.enable
                 && !store_skip;
    score_pk   = s_r[SCOREPK_W-1:0] + SCORE_BIAS_PK;
    new_dat    = {kind_r, depth_r, score_pk, move_r};

    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else begin
      wr_en   = store_go;
      wr_addr = key_r[INDEX_BITS-1:0];
      wr_data = {key_r ^ new_dat, new_dat};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (&clr_cnt_r) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_r    <= in_operation;
            key_r   <= in_key;
            alpha_r <= in_alpha;
            beta_r  <= in_beta;
            depth_r <= in_depth;
            ply_r   <= in_ply;
            score_r <= in_score;
            kind_r  <= in_bound_kind;
            move_r  <= in_best_move;
            state_r <= ST_ADJ1;
          end
        end
        ST_ADJ1: begin
          match_r <= ((chk ^ dat) == key_r);
          s_r     <= s1_nxt;
          state_r <= ST_ADJ2;
        end
        ST_ADJ2: begin
          s_r     <= s2_nxt;
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          out_valid        <= 1'b1;
          out_hit          <= 1'b0;
          out_found_move   <= '0;
          out_found_score  <= '0;
          out_found_depth  <= '0;
          out_found_kind   <= '0;
          out_cutoff_valid <= 1'b0;
          out_cutoff_score <= '0;
          out_written      <= store_go;
          // disabled table, probe miss or store: found and cutoff fields stay zero
          if (cfg_r.enable && op_r == OP_PROBE && match_r) begin
            out_hit          <= 1'b1;
            out_found_move   <= dat[MOVE_W-1:0];
            out_found_score  <= s_r[SCORE_W-1:0];
            out_found_depth  <= sdepth;
            out_found_kind   <= skind;
            out_cutoff_valid <= cut_nxt;
            out_cutoff_score <= cut_score_nxt;
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* dv/tb_transposition_table_probe_store_unit.sv */
// ----------------------------------------------------------------------------
// tb_transposition_table_probe_store_unit
// Self-checking bench for the probe/store unit. A directed table covers empty
// slots, extreme scores and depths, the replacement rule, kind three and the
// disabled table. Random phases follow, each with its own register setting.
// Every result is checked field by field against a fixed expectation for
// typed rows, else against a predictor with its own copy of both slot stores.
// ----------------------------------------------------------------------------
module tb_transposition_table_probe_store_unit;
  import ttps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int    INDEX_BITS = DEFAULT_INDEX_BITS;
  localparam int    SLOTS      = 1 << INDEX_BITS;
  localparam longint BIAS      = 1 << 20;

  typedef struct {
    logic                      op;
    logic [KEY_W-1:0]          key;
    logic signed [SCORE_W-1:0] alpha;
    logic signed [SCORE_W-1:0] beta;
    logic [DEPTH_W-1:0]        depth;
    logic [PLY_W-1:0]          ply;
    logic signed [SCORE_W-1:0] score;
    logic [KIND_W-1:0]         kind;
    logic [MOVE_W-1:0]         move;
  } tt_item_t;

  typedef struct {
    logic                      hit;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic [KIND_W-1:0]         kind;
    logic                      cut_ok;
    logic signed [SCORE_W-1:0] cut_score;
    logic                      written;
  } tt_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             rk;
    tt_item_t              it;
    logic [CFG_IDX_W-1:0]  idx;
    logic [THR_W-1:0]      data;
    bit                    typed;
    tt_result_t            want;
  } stim_row_t;

  logic                      clk;
  logic                      rst_n            = 1'b0;
  logic                      start            = 1'b0;
  logic                      busy;
  logic                      in_operation     = OP_PROBE;
  logic [KEY_W-1:0]          in_key           = '0;
  logic signed [SCORE_W-1:0] in_alpha         = '0;
  logic signed [SCORE_W-1:0] in_beta          = '0;
  logic [DEPTH_W-1:0]        in_depth         = '0;
  logic [PLY_W-1:0]          in_ply           = '0;
  logic signed [SCORE_W-1:0] in_score         = '0;
  logic [KIND_W-1:0]         in_bound_kind    = KIND_EXACT;
  logic [MOVE_W-1:0]         in_best_move     = '0;
  logic                      out_valid;
  logic                      out_hit;
  logic [MOVE_W-1:0]         out_found_move;
  logic signed [SCORE_W-1:0] out_found_score;
  logic [DEPTH_W-1:0]        out_found_depth;
  logic [KIND_W-1:0]         out_found_kind;
  logic                      out_cutoff_valid;
  logic signed [SCORE_W-1:0] out_cutoff_score;
  logic                      out_written;
  logic                      cfg_valid        = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index        = CFG_IDX_ENABLE;
  logic [THR_W-1:0]          cfg_data         = '0;

  // predictor copy of the table and registers
  logic [WORD_W-1:0] check_mem [SLOTS];
  logic [WORD_W-1:0] data_mem  [SLOTS];
  logic              tbl_enable;
  logic [THR_W-1:0]  tbl_threshold;

  tt_result_t    pending_results [$];
  stim_row_t     stim_rows [$];
  logic [63:0]   key_pool [16];
  int            err_count = 0;
  int            burst_left = 0;
  int            n_probe = 0, n_store = 0, n_hit = 0, n_cut = 0, n_written = 0;
  int            n_cfg = 0;

  transposition_table_probe_store_unit #(.INDEX_BITS(INDEX_BITS)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_key(in_key), .in_alpha(in_alpha),
    .in_beta(in_beta), .in_depth(in_depth), .in_ply(in_ply), .in_score(in_score),
    .in_bound_kind(in_bound_kind), .in_best_move(in_best_move),
    .out_valid(out_valid), .out_hit(out_hit), .out_found_move(out_found_move),
    .out_found_score(out_found_score), .out_found_depth(out_found_depth),
    .out_found_kind(out_found_kind), .out_cutoff_valid(out_cutoff_valid),
    .out_cutoff_score(out_cutoff_score), .out_written(out_written),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("transposition_table_probe_store_unit regression: fail");
    $finish;
  end

  // Work out the result of one item and update the predictor table.
  function automatic tt_result_t probe_store_result(tt_item_t it);
    tt_result_t              r;
    logic [INDEX_BITS-1:0]   slot;
    logic [WORD_W-1:0]       chk, dat, nd;
    logic                    same_key;
    longint                  s, thr, a, b, p;
    r = '{default: '0};
    if (!tbl_enable) return r;
    slot     = it.key[INDEX_BITS-1:0];
    chk      = check_mem[slot];
    dat      = data_mem[slot];
    same_key = ((chk ^ dat) == it.key);
    thr      = longint'(tbl_threshold);
    p        = longint'(it.ply);
    a        = longint'(it.alpha);
    b        = longint'(it.beta);
    if (it.op == OP_PROBE) begin
      if (!same_key) return r;
      s = longint'(dat[SCORE_POS +: SCOREPK_W]) - BIAS;
      if (s < -thr) s = s + p;
      if (s > thr) s = s - p;
      r.hit   = 1'b1;
      r.move  = dat[MOVE_W-1:0];
      r.score = s[SCORE_W-1:0];
      r.depth = dat[DEPTH_POS +: DEPTH_W];
      r.kind  = dat[KIND_POS +: KIND_W];
      if (r.depth >= it.depth) begin
        if (r.kind == KIND_EXACT) begin
          r.cut_ok    = 1'b1;
          r.cut_score = s[SCORE_W-1:0];
        end else if (r.kind == KIND_ALPHA && s <= a) begin
          r.cut_ok    = 1'b1;
          r.cut_score = it.alpha;
        end else if (r.kind == KIND_BETA && s >= b) begin
          r.cut_ok    = 1'b1;
          r.cut_score = it.beta;
        end
      end
      return r;
    end
    // keep a deeper entry of the same position unless the new one is exact
    if (same_key && dat[DEPTH_POS +: DEPTH_W] > it.depth && it.kind != KIND_EXACT)
      return r;
    s = longint'(it.score);
    if (s < -thr) s = s - p;
    if (s > thr) s = s + p;
    s  = s + BIAS;
    nd = {it.kind, it.depth, s[SCOREPK_W-1:0], it.move};
    data_mem[slot]  = nd;
    check_mem[slot] = it.key ^ nd;
    r.written = 1'b1;
    return r;
  endfunction

  function automatic tt_item_t mk_item(logic op, logic [63:0] key,
                                       logic signed [SCORE_W-1:0] alpha,
                                       logic signed [SCORE_W-1:0] beta,
                                       logic [7:0] depth, logic [7:0] ply,
                                       logic signed [SCORE_W-1:0] score,
                                       logic [KIND_W-1:0] kind, logic [31:0] move);
    tt_item_t it;
    it = '{op, key, alpha, beta, depth, ply, score, kind, move};
    return it;
  endfunction

  function automatic void add_item(tt_item_t it);
    stim_rows.push_back('{ROW_ITEM, it, CFG_IDX_ENABLE, '0, 1'b0, '{default: '0}});
  endfunction

  function automatic void add_typed(tt_item_t it, tt_result_t want);
    stim_rows.push_back('{ROW_ITEM, it, CFG_IDX_ENABLE, '0, 1'b1, want});
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
    tt_item_t it;
    it = '{default: '0};
    stim_rows.push_back('{ROW_CFG, it, idx, data, 1'b0, '{default: '0}});
  endfunction

  function automatic logic signed [SCORE_W-1:0] pick_score(longint thr);
    longint v;
    case ($urandom_range(0, 7))
      0:       v = -1048576;
      1:       v = 1048575;
      2:       v = thr + longint'($urandom_range(0, 6)) - 3;
      3:       v = -thr + longint'($urandom_range(0, 6)) - 3;
      4:       v = longint'($urandom_range(0, 200)) - 100;
      default: v = longint'($urandom);
    endcase
    return v[SCORE_W-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Send one item; start stays high afterward so the next item can follow.
  task automatic send_item(tt_item_t it, bit typed, tt_result_t want);
    int         gap;
    tt_result_t pred;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      gap = 0;
      burst_left = $urandom_range(8, 30);
    end else begin
      gap = $urandom_range(0, 11);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_operation  <= it.op;
    in_key        <= it.key;
    in_alpha      <= it.alpha;
    in_beta       <= it.beta;
    in_depth      <= it.depth;
    in_ply        <= it.ply;
    in_score      <= it.score;
    in_bound_kind <= it.kind;
    in_best_move  <= it.move;
    do @(posedge clk); while (busy !== 1'b0);
    pred = probe_store_result(it);
    pending_results.push_back(typed ? want : pred);
    if (it.op == OP_PROBE) n_probe++;
    else n_store++;
  endtask

  // Hold off the sender until every result is back, then let the pipe settle.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_IDX_ENABLE) tbl_enable = data[0];
    else tbl_threshold = data;
    n_cfg++;
  endtask

  always @(posedge clk) begin
    tt_result_t got, want;
    if (rst_n && out_valid === 1'b1) begin
      got = '{out_hit, out_found_move, out_found_score, out_found_depth,
              out_found_kind, out_cutoff_valid, out_cutoff_score, out_written};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'd0, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit)
          report_mismatch("hit", 64'(got.hit), 64'(want.hit));
        if (got.move !== want.move)
          report_mismatch("found_move", 64'(got.move), 64'(want.move));
        if (got.score !== want.score)
          report_mismatch("found_score", 64'(got.score), 64'(want.score));
        if (got.depth !== want.depth)
          report_mismatch("found_depth", 64'(got.depth), 64'(want.depth));
        if (got.kind !== want.kind)
          report_mismatch("found_kind", 64'(got.kind), 64'(want.kind));
        if (got.cut_ok !== want.cut_ok)
          report_mismatch("cutoff_valid", 64'(got.cut_ok), 64'(want.cut_ok));
        if (got.cut_score !== want.cut_score)
          report_mismatch("cutoff_score", 64'(got.cut_score), 64'(want.cut_score));
        if (got.written !== want.written)
          report_mismatch("written", 64'(got.written), 64'(want.written));
      end
      n_hit     += int'(got.hit === 1'b1);
      n_cut     += int'(got.cut_ok === 1'b1);
      n_written += int'(got.written === 1'b1);
    end
  end

  initial begin
    tt_result_t  none, wr_only, empty_hit;
    tt_item_t    it;
    stim_row_t   row;
    logic [63:0] k1, k2, k3, k3b, k4, k5, k6;
    logic        en;
    logic [THR_W-1:0] thr;
    int          n;

    for (int i = 0; i < SLOTS; i++) begin
      check_mem[i] = '0;
      data_mem[i]  = '0;
    end
    tbl_enable    = ENABLE_RESET;
    tbl_threshold = THRESHOLD_RESET;

    // pairs of pool keys share a slot so that collisions are common, but for the last key, which is zero
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = {$urandom, $urandom};
      if (i % 2 == 1) key_pool[i][INDEX_BITS-1:0] = key_pool[i-1][INDEX_BITS-1:0];
    end
    key_pool[15] = '0;

    none      = '{default: '0};
    wr_only   = none;
    wr_only.written = 1'b1;
    // an all-zero slot matches key zero and unpacks to the most negative score
    empty_hit = '{1'b1, '0, -21'sd1048576, '0, KIND_EXACT, 1'b1, -21'sd1048576, 1'b0};

    k1  = 64'hFFFF_FFFF_FFFF_FFFF;
    k2  = 64'h8000_0000_0000_0ABC;
    k3  = 64'h0123_4567_89AB_C123;
    k3b = 64'hFEDC_BA98_7654_3123;
    k4  = 64'h5555_AAAA_5555_A001;
    k5  = 64'h2A2A_0000_1111_0777;
    k6  = 64'h7FFF_FFFF_FFFF_F555;

    add_cfg(CFG_IDX_ENABLE, 20'd1);
    add_cfg(CFG_IDX_THRESHOLD, THRESHOLD_RESET);
    add_typed(mk_item(OP_PROBE, 64'd0, 0, 0, 0, 0, 0, KIND_EXACT, 0), empty_hit);
    add_typed(mk_item(OP_PROBE, 64'hFFFF_FFFF_FFFF_F000, 0, 0, 0, 0, 0, KIND_EXACT, 0),
              none);
    add_typed(mk_item(OP_STORE, k1, 0, 0, 255, 255, 1048575, KIND_EXACT, 32'hFFFF_FFFF),
              wr_only);
    add_item(mk_item(OP_PROBE, k1, -1048576, 1048575, 255, 0, 0, KIND_EXACT, 0));
    add_item(mk_item(OP_PROBE, k1, 1048575, -1048576, 0, 255, 0, KIND_EXACT, 0));
    add_typed(mk_item(OP_STORE, k1, 0, 0, 10, 0, 5, KIND_ALPHA, 32'h1234), none);
    add_typed(mk_item(OP_STORE, k1, 0, 0, 10, 0, 0, KIND_EXACT, 0), wr_only);
    add_item(mk_item(OP_PROBE, k1, 0, 0, 11, 3, 0, KIND_EXACT, 0));
    add_typed(mk_item(OP_STORE, k2, 0, 0, 20, 255, -1048576, KIND_BETA, 32'h8000_0001),
              wr_only);
    add_item(mk_item(OP_PROBE, k2, 0, -1048576, 20, 0, 0, KIND_EXACT, 0));
    add_typed(mk_item(OP_STORE, k3, 0, 0, 5, 0, 0, KIND_ALPHA, 32'h0000_0F0F), wr_only);
    add_item(mk_item(OP_PROBE, k3, 0, 0, 5, 0, 0, KIND_EXACT, 0));
    add_item(mk_item(OP_PROBE, k3, -1, 0, 5, 0, 0, KIND_EXACT, 0));
    add_item(mk_item(OP_STORE, k3, 0, 0, 5, 0, 100, KIND_BETA, 32'h0000_F0F0));
    add_item(mk_item(OP_STORE, k3b, 0, 0, 0, 0, -5, KIND_ALPHA, 32'h5A5A_5A5A));
    add_item(mk_item(OP_PROBE, k3, 0, 0, 0, 0, 0, KIND_EXACT, 0));
    add_item(mk_item(OP_STORE, k4, 0, 0, 3, 0, 77, 2'd3, 32'hA5A5_A5A5));
    add_item(mk_item(OP_PROBE, k4, 1048575, -1048576, 0, 0, 0, KIND_EXACT, 0));
    add_item(mk_item(OP_STORE, k5, 0, 0, 1, 7, 48001, KIND_EXACT, 32'h0000_0777));
    add_item(mk_item(OP_PROBE, k5, 0, 0, 1, 7, 0, KIND_EXACT, 0));
    add_item(mk_item(OP_STORE, k6, 0, 0, 2, 9, -48001, KIND_ALPHA, 32'h0000_0555));
    add_item(mk_item(OP_PROBE, k6, 0, 0, 2, 9, 0, KIND_EXACT, 0));
    add_cfg(CFG_IDX_ENABLE, 20'd0);
    add_typed(mk_item(OP_STORE, k5, 0, 0, 200, 0, 1, KIND_EXACT, 32'hDEAD_0001), none);
    add_typed(mk_item(OP_PROBE, k5, 0, 0, 0, 0, 0, KIND_EXACT, 0), none);
    add_cfg(CFG_IDX_ENABLE, 20'd1);
    add_item(mk_item(OP_PROBE, k5, 0, 0, 0, 0, 0, KIND_EXACT, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.rk == ROW_CFG) begin
        wait_drained();
        write_reg(row.idx, row.data);
        cfg_valid <= 1'b0;
      end else begin
        send_item(row.it, row.typed, row.want);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      en = 1'b1;
      n  = 78;
      case (ph)
        0: thr = THRESHOLD_RESET;
        1: thr = '0;
        2: thr = '1;
        3: begin
          thr = THR_W'($urandom);
          en  = 1'b0;
          n   = 15;
        end
        4: thr = THR_W'($urandom_range(0, 300));
        default: thr = THR_W'($urandom);
      endcase
      wait_drained();
      write_reg(CFG_IDX_ENABLE, {19'($urandom), en});
      write_reg(CFG_IDX_THRESHOLD, thr);
      cfg_valid <= 1'b0;
      for (int j = 0; j < n; j++) begin
        it.op    = $urandom_range(0, 1) ? OP_STORE : OP_PROBE;
        it.key   = ($urandom_range(0, 6) == 0) ? {$urandom, $urandom}
                                                : key_pool[$urandom_range(0, 15)];
        it.alpha = pick_score(longint'(thr));
        it.beta  = pick_score(longint'(thr));
        it.score = pick_score(longint'(thr));
        it.depth = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
        it.ply   = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
        it.kind  = ($urandom_range(0, 9) == 0) ? 2'd3 : KIND_W'($urandom_range(0, 2));
        it.move  = $urandom;
        send_item(it, 1'b0, none);
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never arrived", 64'(pending_results.size()), 64'd0);

    $display("Ran %0d probes and %0d stores over %0d register writes.",
             n_probe, n_store, n_cfg);
    $display("Saw %0d hits, %0d cutoffs and %0d slot writes; %0d mismatches.",
             n_hit, n_cut, n_written, err_count);
    if (err_count == 0) begin
      $display("transposition_table_probe_store_unit regression: pass");
    end else begin
      $display("transposition_table_probe_store_unit regression: fail");
    end
    $finish;
  end

endmodule
